@@ hw/rtl/bdu_pkg.sv @@
// Shared types and constants of the box downsampler with unpremultiply.
package bdu_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 16384;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int CW_W         = 13;
    localparam int CH_W         = 15;
    localparam int CS_W         = 2;
    localparam int SUM_W        = 22;
    localparam int PIX_W        = 16;
    localparam int NUM_W        = 32;
    localparam int CNT_W        = 7;
    localparam int STEP_W       = 3;

    // register indexes of the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SHIFT  = 2'd2;

    // divide steps: four block averages, then three unpremultiplies
    localparam logic [STEP_W-1:0] STEP_ALPHA_AVG = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LAST      = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT_LOAD
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              acc;
        logic              div_start;
        logic              capture;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/bdu_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bdu_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bdu_pkg::NUM_W-1:0] numer,
    input  logic [bdu_pkg::PIX_W-1:0] denom,
    output logic                      done,
    output logic [bdu_pkg::NUM_W-1:0] quot
);

    localparam int ITER_W = $clog2(bdu_pkg::NUM_W);

    logic                      busy_reg,  busy_next;
    logic                      done_reg,  done_next;
    logic [ITER_W-1:0]         iter_reg,  iter_next;
    logic [bdu_pkg::NUM_W-1:0] q_reg,     q_next;
    logic [bdu_pkg::PIX_W-1:0] rem_reg,   rem_next;
    logic [bdu_pkg::PIX_W-1:0] den_reg,   den_next;
    logic [bdu_pkg::PIX_W:0]   rem_shift;
    logic [bdu_pkg::PIX_W:0]   rem_diff;

    // shift in one numerator bit and try to subtract
    always_comb
    begin
        rem_shift = {rem_reg, q_reg[bdu_pkg::NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            q_next    = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[bdu_pkg::PIX_W-1:0];
                q_next   = {q_reg[bdu_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[bdu_pkg::PIX_W-1:0];
                q_next   = {q_reg[bdu_pkg::NUM_W-2:0], 1'b0};
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(bdu_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    // hold operands
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ hw/rtl/bdu_dp.sv @@
// Datapath: configuration, positions, column sums memory, averaging, unpremultiply and output register.
module bdu_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdu_pkg::dp_cmd_t         cmd,
    output bdu_pkg::dp_status_t      status,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [bdu_pkg::CH_W-1:0] cfg_data,
    input  logic [63:0]              in_data,
    output logic [55:0]              out_data,
    output logic                     out_last,
    output logic                     out_valid,
    input  logic                     out_ready
);

    localparam int MEM_W = 4 * bdu_pkg::SUM_W;

    logic [bdu_pkg::CW_W-1:0]  cfg_w_reg;
    logic [bdu_pkg::CH_W-1:0]  cfg_h_reg;
    logic [bdu_pkg::CS_W-1:0]  cfg_s_reg;
    logic [bdu_pkg::COL_W-1:0] pos_x_reg, pos_x_next;
    logic [bdu_pkg::ROW_W-1:0] pos_y_reg, pos_y_next;

    logic [MEM_W-1:0] sum_mem [bdu_pkg::MAX_WIDTH];
    logic [MEM_W-1:0] rd_reg;

    logic [3:0][bdu_pkg::PIX_W-1:0] in_reg;
    logic [bdu_pkg::COL_W-1:0]      col_reg;
    logic                           fresh_reg;
    logic                           emit_reg;
    logic                           done_flag_reg;
    logic [bdu_pkg::CNT_W-1:0]      count_reg;
    logic [3:0][bdu_pkg::SUM_W-1:0] sum_reg;
    logic [3:0][bdu_pkg::SUM_W-1:0] sum_next;
    logic [3:0][bdu_pkg::PIX_W-1:0] avg_reg;
    logic [2:0][bdu_pkg::PIX_W-1:0] color_reg;

    logic [bdu_pkg::CW_W-1:0]  w_eff;
    logic [bdu_pkg::CH_W-1:0]  h_eff;
    logic [2:0]                mask;
    logic [3:0]                side;
    logic [bdu_pkg::COL_W-1:0] x_eff, x_base, col;
    logic [bdu_pkg::ROW_W-1:0] y_eff, y_base;
    logic                      x_end, y_end, fresh, last_x, last_y;
    logic [bdu_pkg::CW_W-1:0]  bw_full;
    logic [bdu_pkg::CH_W-1:0]  bh_full;
    logic [3:0]                bw, bh;
    logic [7:0]                count_full;

    logic [bdu_pkg::NUM_W-1:0] div_num;
    logic [bdu_pkg::PIX_W-1:0] div_den;
    logic                      div_done;
    logic [bdu_pkg::NUM_W-1:0] div_q;
    logic [bdu_pkg::PIX_W-1:0] q_sat;
    logic [bdu_pkg::PIX_W-1:0] color_sel;
    logic [bdu_pkg::PIX_W-1:0] alpha_avg;
    logic [23:0]               alpha_scaled;
    logic [7:0]                alpha_hi;
    logic [16:0]               alpha_rem;
    logic [7:0]                alpha_byte;
    logic                      out_valid_reg;
    logic [55:0]               out_data_reg;
    logic                      out_last_reg;

    // clamp the geometry registers
    always_comb
    begin
        if (cfg_w_reg == '0)
            w_eff = 13'd1;
        else if (cfg_w_reg > bdu_pkg::CW_W'(bdu_pkg::MAX_WIDTH))
            w_eff = bdu_pkg::CW_W'(bdu_pkg::MAX_WIDTH);
        else
            w_eff = cfg_w_reg;
        if (cfg_h_reg == '0)
            h_eff = 15'd1;
        else if (cfg_h_reg > bdu_pkg::CH_W'(bdu_pkg::HEIGHT_LIMIT))
            h_eff = bdu_pkg::CH_W'(bdu_pkg::HEIGHT_LIMIT);
        else
            h_eff = cfg_h_reg;
        side = 4'd1 << cfg_s_reg;
        mask = 3'(side - 4'd1);
    end

    // locate the current pixel in its block
    always_comb
    begin
        x_eff  = ({1'b0, pos_x_reg} >= w_eff) ? '0 : pos_x_reg;
        y_eff  = ({1'b0, pos_y_reg} >= h_eff) ? '0 : pos_y_reg;
        x_base = x_eff & ~{{(bdu_pkg::COL_W-3){1'b0}}, mask};
        y_base = y_eff & ~{{(bdu_pkg::ROW_W-3){1'b0}}, mask};
        col    = x_eff >> cfg_s_reg;
        x_end  = ({1'b0, x_eff} == w_eff - 13'd1);
        y_end  = ({1'b0, y_eff} == h_eff - 15'd1);
        fresh  = ((x_eff[2:0] & mask) == 3'd0) && ((y_eff[2:0] & mask) == 3'd0);
        last_x = ((x_eff[2:0] & mask) == mask) || x_end;
        last_y = ((y_eff[2:0] & mask) == mask) || y_end;
        bw_full = w_eff - {1'b0, x_base};
        bh_full = h_eff - {1'b0, y_base};
        bw = (bw_full > {9'h0, side}) ? side : bw_full[3:0];
        bh = (bh_full > {11'h0, side}) ? side : bh_full[3:0];
        count_full = {4'h0, bw} * {4'h0, bh};
        // advance raster position
        if (x_end)
        begin
            pos_x_next = '0;
            pos_y_next = y_end ? '0 : y_eff + 1'b1;
        end
        else
        begin
            pos_x_next = x_eff + 1'b1;
            pos_y_next = y_eff;
        end
    end

    // write configuration and advance position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= 13'd1;
            cfg_h_reg <= 15'd1;
            cfg_s_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bdu_pkg::REG_WIDTH:  cfg_w_reg <= cfg_data[bdu_pkg::CW_W-1:0];
                    bdu_pkg::REG_HEIGHT: cfg_h_reg <= cfg_data;
                    bdu_pkg::REG_SHIFT:  cfg_s_reg <= cfg_data[bdu_pkg::CS_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.accept)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
        end
    end

    // capture the request and its block facts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_reg <= 1'b0;
        else if (cmd.accept)
            emit_reg <= last_x && last_y;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_reg        <= in_data;
            col_reg       <= col;
            fresh_reg     <= fresh;
            done_flag_reg <= x_end && y_end;
            count_reg     <= count_full[bdu_pkg::CNT_W-1:0];
        end
    end

    // column sums memory: read on accept, write back in the cycle after
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rd_reg <= sum_mem[col];
        if (cmd.acc)
            sum_mem[col_reg] <= sum_next;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (fresh_reg)
                sum_next[i] = bdu_pkg::SUM_W'(in_reg[i]);
            else
                sum_next[i] = rd_reg[i*bdu_pkg::SUM_W +: bdu_pkg::SUM_W]
                              + bdu_pkg::SUM_W'(in_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
            sum_reg <= sum_next;
    end

    // select divider operands for the current step
    always_comb
    begin
        alpha_avg = avg_reg[3];
        color_sel = avg_reg[0];
        unique case (cmd.step)
            3'd5:    color_sel = avg_reg[1];
            3'd6:    color_sel = avg_reg[2];
            default: color_sel = avg_reg[0];
        endcase
        if (cmd.step <= bdu_pkg::STEP_ALPHA_AVG)
        begin
            div_num = bdu_pkg::NUM_W'(sum_reg[cmd.step[1:0]])
                      + bdu_pkg::NUM_W'(count_reg >> 1);
            div_den = bdu_pkg::PIX_W'(count_reg);
        end
        else
        begin
            div_num = ({color_sel, 16'h0} - {16'h0, color_sel})
                      + {17'h0, alpha_avg[15:1]};
            div_den = alpha_avg;
        end
        q_sat = (div_q[31:16] != 16'h0) ? 16'hFFFF : div_q[15:0];
    end

    bdu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // store averages and straight colors
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (cmd.step <= bdu_pkg::STEP_ALPHA_AVG)
                avg_reg[cmd.step[1:0]] <= q_sat;
            else
                color_reg[2'(cmd.step - 3'd4)] <= (alpha_avg == '0) ? '0 : q_sat;
        end
    end

    // round alpha to eight bits: divide by 65535 with one correction
    always_comb
    begin
        alpha_scaled = ({alpha_avg, 8'h0} - {8'h0, alpha_avg}) + 24'd32767;
        alpha_hi     = alpha_scaled[23:16];
        alpha_rem    = {1'b0, alpha_scaled[15:0]} + {9'h0, alpha_hi};
        alpha_byte   = (alpha_rem >= 17'd65535) ? alpha_hi + 8'd1 : alpha_hi;
    end

    // output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {alpha_byte, color_reg[2], color_reg[1], color_reg[0]};
            out_last_reg <= done_flag_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_last        = out_last_reg;
    assign status.emit     = emit_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

@@ hw/rtl/bdu_ctrl.sv @@
// Controller: sequences accumulate per request, then divide steps and output load when a block closes.
module bdu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bdu_pkg::dp_status_t status,
    output bdu_pkg::dp_cmd_t    cmd
);

    bdu_pkg::state_t             state_reg, state_next;
    logic [bdu_pkg::STEP_W-1:0]  step_reg,  step_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            bdu_pkg::ST_IDLE:
                if (in_valid)
                    state_next = bdu_pkg::ST_ACC;
            bdu_pkg::ST_ACC:
            begin
                step_next  = '0;
                state_next = status.emit ? bdu_pkg::ST_DIV_START : bdu_pkg::ST_IDLE;
            end
            bdu_pkg::ST_DIV_START:
                state_next = bdu_pkg::ST_DIV_WAIT;
            bdu_pkg::ST_DIV_WAIT:
                if (status.div_done)
                begin
                    if (step_reg == bdu_pkg::STEP_LAST)
                        state_next = bdu_pkg::ST_OUT_LOAD;
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = bdu_pkg::ST_DIV_START;
                    end
                end
            bdu_pkg::ST_OUT_LOAD:
                if (status.out_free)
                    state_next = bdu_pkg::ST_IDLE;
            default:
                state_next = bdu_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        in_ready      = (state_reg == bdu_pkg::ST_IDLE);
        cmd.accept    = (state_reg == bdu_pkg::ST_IDLE) && in_valid;
        cmd.acc       = (state_reg == bdu_pkg::ST_ACC);
        cmd.div_start = (state_reg == bdu_pkg::ST_DIV_START);
        cmd.capture   = (state_reg == bdu_pkg::ST_DIV_WAIT) && status.div_done;
        cmd.load_out  = (state_reg == bdu_pkg::ST_OUT_LOAD) && status.out_free;
        cmd.step      = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdu_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_load_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdu_pkg::ST_OUT_LOAD) |-> (step_reg == bdu_pkg::STEP_LAST))
        else $error("output load before all divide steps");

    a_div_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !status.div_done)
        else $error("divider finished in one cycle");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == bdu_pkg::ST_DIV_WAIT))
        else $error("divider finished outside a divide step");

endmodule

@@ hw/rtl/box_downsample_unpremultiply.sv @@
// Top level of the box downsampler with unpremultiply.
// Accepts premultiplied RGBA16 pixels in raster order, one request at a time. A pixel
// that closes no block is accepted, then its column sum is read, modified and
// written back. A pixel that closes a block then runs seven divides on one shared
// bit-serial divider (four block averages, three unpremultiplies), each a start
// state and a wait for the quotient, and then one output load. The finished
// result sits in an output register, so the next pixel is taken while it waits.
// Column sums live in a 4096-entry memory with no clearing; each block's first
// pixel overwrites its entry.
module box_downsample_unpremultiply (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic        m_axis_tlast,  // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    bdu_pkg::dp_cmd_t    cmd;
    bdu_pkg::dp_status_t status;

    bdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign cfg_ready = 1'b1;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the box downsampler with unpremultiply.
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_WAIT   = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2000;
    localparam int RANDOM_ITEMS = 1750;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [7:0]  alpha;
        logic        frame_done;
    } block_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // red_in, green_in, blue_in, alpha_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // red_out, green_out, blue_out, alpha_out
    logic        m_axis_tlast;   // frame_done
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    box_downsample_unpremultiply DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // mirror of the block's registers and accumulators
    logic [bdu_pkg::CW_W-1:0]  mir_width;
    logic [bdu_pkg::CH_W-1:0]  mir_height;
    logic [bdu_pkg::CS_W-1:0]  mir_shift;
    logic [bdu_pkg::SUM_W-1:0] red_acc   [bdu_pkg::MAX_WIDTH];
    logic [bdu_pkg::SUM_W-1:0] green_acc [bdu_pkg::MAX_WIDTH];
    logic [bdu_pkg::SUM_W-1:0] blue_acc  [bdu_pkg::MAX_WIDTH];
    logic [bdu_pkg::SUM_W-1:0] alpha_acc [bdu_pkg::MAX_WIDTH];
    int unsigned      col_pos;
    int unsigned      row_pos;

    block_pixel_t expected_blocks[$];
    int           error_count;
    int           burst_left;
    int           items_sent;
    bit           hold_request;
    bit           hold_off;
    int           idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (mir_width == 0) return 1;
        if (mir_width > bdu_pkg::MAX_WIDTH) return bdu_pkg::MAX_WIDTH;
        return mir_width;
    endfunction

    function automatic int unsigned eff_height();
        if (mir_height == 0) return 1;
        if (mir_height > bdu_pkg::HEIGHT_LIMIT) return bdu_pkg::HEIGHT_LIMIT;
        return mir_height;
    endfunction

    function automatic logic [15:0] box_average(logic [bdu_pkg::SUM_W-1:0] sum,
                                                int unsigned cnt);
        int unsigned v;
        v = (32'(sum) + cnt / 2) / cnt;
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic logic [15:0] straight_color(logic [15:0] premul, logic [15:0] alpha);
        longint unsigned v;
        if (alpha == 0) return 16'd0;
        v = (64'(premul) * 65535 + 64'(alpha) / 2) / 64'(alpha);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    // advance the mirror by one source pixel; queue the block result if one closes
    task automatic predict_pixel(input logic [63:0] pix);
        int unsigned w, h, s, d, msk, x, y, col, bw, bh;
        bit fresh;
        logic [15:0] ar, ag, ab, aa;
        block_pixel_t res;
        w = eff_width();
        h = eff_height();
        s = mir_shift;
        d = 1 << s;
        msk = d - 1;
        x = (col_pos >= w) ? 0 : col_pos;
        y = (row_pos >= h) ? 0 : row_pos;
        col = (x >> s) % bdu_pkg::MAX_WIDTH;
        fresh = ((x & msk) == 0) && ((y & msk) == 0);
        if (fresh)
        begin
            red_acc[col]   = 22'(pix[15:0]);
            green_acc[col] = 22'(pix[31:16]);
            blue_acc[col]  = 22'(pix[47:32]);
            alpha_acc[col] = 22'(pix[63:48]);
        end
        else
        begin
            red_acc[col]   = red_acc[col]   + 22'(pix[15:0]);
            green_acc[col] = green_acc[col] + 22'(pix[31:16]);
            blue_acc[col]  = blue_acc[col]  + 22'(pix[47:32]);
            alpha_acc[col] = alpha_acc[col] + 22'(pix[63:48]);
        end
        if ((((x & msk) == msk) || (x == w - 1)) && (((y & msk) == msk) || (y == h - 1)))
        begin
            bw = w - (x & ~msk);
            if (bw > d) bw = d;
            bh = h - (y & ~msk);
            if (bh > d) bh = d;
            ar = box_average(red_acc[col], bw * bh);
            ag = box_average(green_acc[col], bw * bh);
            ab = box_average(blue_acc[col], bw * bh);
            aa = box_average(alpha_acc[col], bw * bh);
            res.red        = straight_color(ar, aa);
            res.green      = straight_color(ag, aa);
            res.blue       = straight_color(ab, aa);
            res.alpha      = 8'((32'(aa) * 255 + 32767) / 65535);
            res.frame_done = (x == w - 1) && (y == h - 1);
            expected_blocks.push_back(res);
        end
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    // track accepted requests, check results, watch for a hang
    always @(posedge clk)
    begin
        block_pixel_t want;
        bit           active;
        active = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                active = 1'b1;
                case (cfg_index)
                    bdu_pkg::REG_WIDTH:  mir_width  = cfg_data[bdu_pkg::CW_W-1:0];
                    bdu_pkg::REG_HEIGHT: mir_height = cfg_data[bdu_pkg::CH_W-1:0];
                    bdu_pkg::REG_SHIFT:  mir_shift  = cfg_data[bdu_pkg::CS_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                active = 1'b1;
                predict_pixel(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                active = 1'b1;
                if (expected_blocks.size() == 0)
                begin
                    $error("unexpected result tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (m_axis_tdata[15:0] !== want.red)
                    begin
                        $error("red_out expected %0d got %0d", want.red, m_axis_tdata[15:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[31:16] !== want.green)
                    begin
                        $error("green_out expected %0d got %0d", want.green, m_axis_tdata[31:16]);
                        error_count++;
                    end
                    if (m_axis_tdata[47:32] !== want.blue)
                    begin
                        $error("blue_out expected %0d got %0d", want.blue, m_axis_tdata[47:32]);
                        error_count++;
                    end
                    if (m_axis_tdata[55:48] !== want.alpha)
                    begin
                        $error("alpha_out expected %0d got %0d", want.alpha, m_axis_tdata[55:48]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.frame_done)
                    begin
                        $error("frame_done expected %0b got %0b", want.frame_done, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            idle_cycles <= active ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL box_downsample_unpremultiply");
                $finish;
            end
        end
    end

    // receiver: rotate through always-ready, random and mostly-stalled stretches
    always @(posedge clk)
    begin
        int unsigned phase;
        phase = 32'(($time / 20) % 600);
        if (!rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else if (phase < 200)
            m_axis_tready <= 1'b1;
        else if (phase < 400)
            m_axis_tready <= $urandom_range(0, 1);
        else
            m_axis_tready <= ($urandom_range(0, 3) == 0);
    end

    // long receiver hold-off, counted here
    initial
    begin
        hold_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                hold_request = 1'b0;
            end
        end
    end

    // offer one pixel in bursts; hold valid until it is taken
    task automatic send_pixel(input logic [63:0] pix);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly valid premultiplied pixels, some with color above alpha
    function automatic logic [63:0] rand_pixel();
        logic [15:0] a;
        a = rand_channel();
        if ($urandom_range(0, 3) == 0)
            return {a, rand_channel(), rand_channel(), rand_channel()};
        return {a, 16'($urandom_range(0, a)), 16'($urandom_range(0, a)),
                16'($urandom_range(0, a))};
    endfunction

    // finish the current frame, plus whole frames after it
    task automatic send_frames(input int nframes, input bit random_pix, input logic [63:0] pix);
        int unsigned w, h, x, y, total;
        // let the monitor take the last accepted request into the mirror
        @(negedge clk);
        w = eff_width();
        h = eff_height();
        x = (col_pos >= w) ? 0 : col_pos;
        y = (row_pos >= h) ? 0 : row_pos;
        total = w * h - (y * w + x) + (nframes - 1) * w * h;
        @(posedge clk);
        repeat (total) send_pixel(random_pix ? rand_pixel() : pix);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // wait for all results, then let the divider drain
    task automatic wait_drain();
        @(negedge clk);
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_geometry(input int w, input int h, input int s);
        wait_drain();
        write_reg(bdu_pkg::REG_WIDTH, 15'(w));
        write_reg(bdu_pkg::REG_HEIGHT, 15'(h));
        write_reg(bdu_pkg::REG_SHIFT, 15'(s));
        cfg_valid <= 1'b0;
    endtask

    // default 1x1 geometry after reset: every pixel is a block
    task automatic test_reset_geometry();
        send_pixel(64'h0);
        send_pixel({4{16'hFFFF}});
        send_pixel({16'h8000, 16'h4000, 16'h2000, 16'h1000});
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // channel extremes: zero alpha, opaque, color above alpha
    task automatic test_extremes();
        set_geometry(4, 2, 0);
        send_pixel({16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF});
        send_pixel({16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF});
        send_pixel({16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_pixel({16'h00FF, 16'h0080, 16'h0001, 16'h0000});
        send_frames(1, 1'b0, {16'h8000, 16'hFFFF, 16'h0000, 16'h8000});
    endtask

    // partial blocks at right and bottom edges for each block size
    task automatic test_partial_blocks();
        set_geometry(3, 3, 1);
        send_frames(1, 1'b1, 64'h0);
        set_geometry(10, 2, 3);
        send_frames(1, 1'b1, 64'h0);
        set_geometry(5, 6, 2);
        send_frames(1, 1'b0, {4{16'hFFFF}});
    endtask

    // zero and oversize geometry saturate to the legal bounds
    task automatic test_geometry_limits();
        set_geometry(0, 0, 3);
        send_frames(2, 1'b1, 64'h0);
        // oversize width: two whole blocks of the first row, frame left open
        set_geometry(8191, 0, 3);
        repeat (16) send_pixel(rand_pixel());
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        // oversize height: leave the frame open with single-pixel blocks
        set_geometry(2, 32767, 0);
        repeat (6) send_pixel(rand_pixel());
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        set_geometry(2, 1, 0);
        send_frames(1, 1'b1, 64'h0);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_geometry(4, 4, 0);
        hold_request = 1'b1;
        burst_left = 200;
        send_frames(3, 1'b1, 64'h0);
    endtask

    // random geometry, mostly small, whole frames of random pixels
    task automatic test_random_frames();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: set_geometry($urandom_range(1, 64), $urandom_range(1, 2), 3);
                1: set_geometry($urandom_range(8, 16), $urandom_range(8, 16), 3);
                default: set_geometry($urandom_range(1, 12), $urandom_range(1, 12),
                                      $urandom_range(0, 3));
            endcase
            send_frames($urandom_range(1, 2), 1'b1, 64'h0);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = bdu_pkg::REG_WIDTH;
        cfg_data      = '0;
        mir_width     = 1;
        mir_height    = 1;
        mir_shift     = 0;
        col_pos       = 0;
        row_pos       = 0;
        error_count   = 0;
        burst_left    = 0;
        items_sent    = 0;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_extremes();
        test_partial_blocks();
        test_geometry_limits();
        test_backpressure();
        test_random_frames();
        wait_drain();

        if (error_count == 0)
            $display("PASS box_downsample_unpremultiply");
        else
            $display("FAIL box_downsample_unpremultiply");
        $finish;
    end

endmodule
